### hdl/otb_pkg.sv
// ----------------------------------------------------------------------------
// otb_pkg: shared types and constants of the one-shot timer bank
// Command and result beats, opcodes, result kinds and sequencer states.
// ----------------------------------------------------------------------------
package otb_pkg;

   localparam int DefChannels = 16;
   localparam int ResultCap   = 16;
   localparam int CountWidth  = 31;
   localparam int ChanWidth   = 8;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      K_ACCEPTED   = 3'd0,
      K_REJECTED   = 3'd1,
      K_EXPIRED    = 3'd2,
      K_REMAINING  = 3'd3,
      K_NOT_ACTIVE = 3'd4,
      K_NO_EXPIRY  = 3'd5
   } kind_type;

   typedef struct packed {
      op_type                opcode;
      logic [ChanWidth-1:0]  channel;
      logic [CountWidth-1:0] length;
   } req_type;

   typedef struct packed {
      kind_type              kind;
      logic [ChanWidth-1:0]  channel_out;
      logic [CountWidth-1:0] remaining;
      logic                  last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_QUERY_RD,
      S_QUERY_RSP,
      S_TICK_RD,
      S_TICK_UPD,
      S_TICK_END
   } state_type;

endpackage

### hdl/otb_count_ram.sv
// ----------------------------------------------------------------------------
// otb_count_ram: remaining-count store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module otb_count_ram
   import otb_pkg::*;
#(
   parameter int DEPTH = DefChannels,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [CountWidth-1:0] wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [CountWidth-1:0] rd_data
);

   logic [CountWidth-1:0] mem [DEPTH];
   logic [CountWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/otb_seq.sv
// ----------------------------------------------------------------------------
// otb_seq: command sequencer of the timer bank
// Holds the active flags, walks the channels on a tick through one shared
// decrementer, and builds every result beat.
// ----------------------------------------------------------------------------
module otb_seq
   import otb_pkg::*;
#(
   parameter int CHANNELS = DefChannels,
   parameter int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output logic [CountWidth-1:0] wr_data,
   output logic [AW-1:0]         rd_addr,
   input  logic [CountWidth-1:0] rd_data
);

   localparam logic [AW-1:0]        LastIdx  = AW'(CHANNELS - 1);
   localparam logic [ChanWidth-1:0] ChanLim  = ChanWidth'(CHANNELS);
   localparam int                   RptWidth = $clog2(ResultCap + 1);
   localparam logic [RptWidth-1:0]  RptCap   = RptWidth'(ResultCap);

   state_type             state_ff, state_in;
   req_type               cmd_ff, cmd_in;
   logic [CHANNELS-1:0]   flags_ff, flags_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [RptWidth-1:0]   rpt_ff, rpt_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_ch_ff, pend_ch_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  cmd_valid;
   logic [AW-1:0]         cmd_idx;
   logic                  hit;
   logic [CountWidth-1:0] dec;

   assign cmd_valid = cmd_ff.channel < ChanLim;
   assign cmd_idx   = cmd_ff.channel[AW-1:0];

   // shared decrementer
   assign dec = rd_data - CountWidth'(1);
   assign hit = flags_ff[idx_ff] && (rd_data != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         flags_ff      <= '0;
         idx_ff        <= '0;
         rpt_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flags_ff      <= flags_in;
         idx_ff        <= idx_in;
         rpt_ff        <= rpt_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      pend_ch_ff <= pend_ch_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      flags_in      = flags_ff;
      idx_in        = idx_ff;
      rpt_in        = rpt_ff;
      pend_in       = pend_ff;
      pend_ch_in    = pend_ch_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = cmd_idx;
      wr_data       = cmd_ff.length;
      rd_addr       = cmd_idx;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in  = req_data;
               idx_in  = '0;
               rpt_in  = '0;
               pend_in = 1'b0;
               case (req_data.opcode)
                  OP_TICK:  state_in = S_TICK_RD;
                  OP_QUERY: state_in = S_QUERY_RD;
                  default:  state_in = S_EXEC;
               endcase
            end
         end

         S_EXEC: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.channel_out = cmd_ff.channel;
            rsp_in.remaining   = '0;
            rsp_in.last        = 1'b1;
            rsp_in.kind        = K_REJECTED;
            if (cmd_ff.opcode == OP_START) begin
               if (cmd_valid && (cmd_ff.length != '0)) begin
                  wr_en             = 1'b1;
                  flags_in[cmd_idx] = 1'b1;
                  rsp_in.kind       = K_ACCEPTED;
               end
            end else if (cmd_valid) begin
               flags_in[cmd_idx] = 1'b0;
               rsp_in.kind       = K_ACCEPTED;
            end
            state_in = S_IDLE;
         end

         S_QUERY_RD: begin
            state_in = S_QUERY_RSP;
         end

         S_QUERY_RSP: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.channel_out = cmd_ff.channel;
            rsp_in.last        = 1'b1;
            if (cmd_valid && flags_ff[cmd_idx]) begin
               rsp_in.kind      = K_REMAINING;
               rsp_in.remaining = rd_data;
            end else begin
               rsp_in.kind      = K_NOT_ACTIVE;
               rsp_in.remaining = '0;
            end
            state_in = S_IDLE;
         end

         S_TICK_RD: begin
            rd_addr  = idx_ff;
            state_in = S_TICK_UPD;
         end

         S_TICK_UPD: begin
            rd_addr = idx_ff;
            wr_addr = idx_ff;
            wr_data = dec;
            wr_en   = hit;
            if (hit && (dec == '0)) begin
               flags_in[idx_ff] = 1'b0;
               if (rpt_ff < RptCap) begin
                  // release the held expiry: another one follows it
                  if (pend_ff) begin
                     rsp_strobe_in      = 1'b1;
                     rsp_in.kind        = K_EXPIRED;
                     rsp_in.channel_out = ChanWidth'(pend_ch_ff);
                     rsp_in.remaining   = '0;
                     rsp_in.last        = 1'b0;
                  end
                  pend_in    = 1'b1;
                  pend_ch_in = idx_ff;
                  rpt_in     = rpt_ff + RptWidth'(1);
               end
            end
            if (idx_ff == LastIdx) begin
               state_in = S_TICK_END;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = S_TICK_RD;
            end
         end

         S_TICK_END: begin
            rsp_strobe_in    = 1'b1;
            rsp_in.remaining = '0;
            rsp_in.last      = 1'b1;
            if (pend_ff) begin
               rsp_in.kind        = K_EXPIRED;
               rsp_in.channel_out = ChanWidth'(pend_ch_ff);
            end else begin
               rsp_in.kind        = K_NO_EXPIRY;
               rsp_in.channel_out = '0;
            end
            pend_in  = 1'b0;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### hdl/one_shot_timer_bank.sv
// ----------------------------------------------------------------------------
// one_shot_timer_bank: bank of one-shot countdown timers
// A command is taken when start is high and busy is low. Results come as
// single-cycle beats marked by rsp_strobe and cannot be held off by the
// receiver. A tick walks every channel through one decrementer and the
// count memory's single read port, one channel after another, with expiry
// beats in ascending channel order and the final one flagged by last.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
module one_shot_timer_bank
   import otb_pkg::*;
#(
   parameter int CHANNELS = DefChannels
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [CountWidth-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [CountWidth-1:0] rd_data;

   otb_count_ram #(
      .DEPTH (CHANNELS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   otb_seq #(
      .CHANNELS (CHANNELS),
      .AW       (AW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

endmodule
